[hdl/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
// Holds the request/response item structs and the label-store control struct.
// No dependencies.
`default_nettype none

package ffba_pkg;

    localparam int SLOTS  = 256;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int LEN_W  = ADDR_W + 1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic [8:0] search_start;
        logic [8:0] block_size;
        logic [7:0] slot_index;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [7:0] start_slot;
        logic [8:0] block_length;
    } rsp_t;

    // Control from the sequencer to the label store.
    typedef struct packed {
        logic              wr_en;
        logic              clr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] wr_label;
        logic [ADDR_W-1:0] rd_addr;
    } label_ctl_t;

    // One label entry as read back; valid low means the slot is empty.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] label;
    } label_entry_t;

endpackage

`default_nettype wire

[hdl/ffba_label_store.sv]
// Label table of the first-fit block allocator: one start label per slot.
// Labels sit in a memory, emptiness in valid flops cleared at reset.
// Depends on ffba_pkg.
`default_nettype none

module ffba_label_store
    import ffba_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire label_ctl_t   ctl,
    output label_entry_t      entry
);

    logic [ADDR_W-1:0] label_mem [SLOTS];
    logic [SLOTS-1:0]  vld_reg;
    logic [ADDR_W-1:0] rd_label_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            label_mem[ctl.wr_addr] <= ctl.wr_label;
        end
        rd_label_reg <= label_mem[ctl.rd_addr];
    end

    // Set on fill, drop on free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                vld_reg[ctl.wr_addr] <= 1'b1;
            end
            else if (ctl.clr_en)
            begin
                vld_reg[ctl.wr_addr] <= 1'b0;
            end
            rd_vld_reg <= vld_reg[ctl.rd_addr];
        end
    end

    assign entry.valid = rd_vld_reg;
    assign entry.label = rd_label_reg;

endmodule

`default_nettype wire

[hdl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: sequencer, used-length mark, result register.
// Depends on ffba_pkg and ffba_label_store.
`default_nettype none

// Usage
// - Request channel (req_valid / req_stall / req): one item carries a command
//   (allocate, free, query), a block size, a search hint and a slot index.
//   req_stall is high whenever the sequencer is busy with an item.
// - Response channel (rsp_valid / rsp_stall / rsp): exactly one item per
//   request, in order: ok flag, block start, block length.
// - One pointer with one increment and one compare against the used length
//   walks the label table one slot per cycle:
//     allocate: a search from the hint up to the used-length mark, then a
//               fill of block_size slots;
//     free / query: a lookup of the slot's label plus a walk over the block;
//     failures caught at the request: no search, lookup or walk.
//   The label memory read is registered, so the read address is the next
//   pointer value.
// - Reset: all slots read as empty at once (valid flops), used length is 0,
//   no response pending. No clearing pass is needed.
// - Receiver stall: the result register holds its item; the sequencer still
//   takes and works one new item, and then waits with its result until the
//   register frees.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_FILL   = 6'b000100,
        S_LOOK   = 6'b001000,
        S_WALK   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  ptr_reg, ptr_next;
    logic [LEN_W-1:0]  run_reg, run_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  used_length_reg, used_length_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [1:0]        cmd_reg, cmd_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    label_ctl_t        ctl;
    label_entry_t      entry;

    logic              out_free;
    logic              ptr_in_use;
    logic [LEN_W:0]    room;
    logic [LEN_W:0]    run_inc;

    ffba_label_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .entry (entry)
    );

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    // The one shared compare: pointer below the used-length mark.
    assign ptr_in_use = ptr_reg < used_length_reg;
    assign room       = (LEN_W+1)'(SLOTS) - {1'b0, used_length_reg};
    assign run_inc    = {1'b0, run_reg} + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        run_next         = run_reg;
        cnt_next         = cnt_reg;
        used_length_next = used_length_reg;
        size_next        = size_reg;
        start_next       = start_reg;
        cmd_next         = cmd_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        ctl              = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = req.command;
                    size_next = req.block_size;
                    res_next  = '0;
                    case (req.command)
                        CMD_ALLOC:
                        begin
                            if (req.block_size == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = req.search_start;
                                run_next   = '0;
                                state_next = S_SEARCH;
                            end
                        end
                        CMD_FREE, CMD_QUERY:
                        begin
                            if ({1'b0, req.slot_index} >= used_length_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = {1'b0, req.slot_index};
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (ptr_in_use)
                begin
                    if (!entry.valid)
                    begin
                        if (run_inc == {1'b0, size_reg})
                        begin
                            // Run complete: fill it from its first slot.
                            ptr_next   = ptr_reg + 1'b1 - size_reg;
                            start_next = ADDR_W'(ptr_reg + 1'b1 - size_reg);
                            cnt_next   = size_reg;
                            state_next = S_FILL;
                        end
                        else
                        begin
                            run_next = run_inc[LEN_W-1:0];
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                else if ({1'b0, size_reg} > room)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Append at the used-length mark and advance the mark.
                    ptr_next         = used_length_reg;
                    start_next       = used_length_reg[ADDR_W-1:0];
                    cnt_next         = size_reg;
                    used_length_next = used_length_reg + size_reg;
                    state_next       = S_FILL;
                end
            end

            S_FILL:
            begin
                ctl.wr_en    = 1'b1;
                ctl.wr_addr  = ptr_reg[ADDR_W-1:0];
                ctl.wr_label = start_reg;
                ptr_next     = ptr_reg + 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == LEN_W'(1))
                begin
                    res_next.ok           = 1'b1;
                    res_next.start_slot   = start_reg;
                    res_next.block_length = size_reg;
                    state_next            = S_DONE;
                end
            end

            S_LOOK:
            begin
                if (!entry.valid || ({1'b0, entry.label} >= used_length_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    start_next = entry.label;
                    ptr_next   = {1'b0, entry.label};
                    cnt_next   = '0;
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                if (ptr_in_use && entry.valid && (entry.label == start_reg))
                begin
                    if (cmd_reg == CMD_FREE)
                    begin
                        ctl.clr_en  = 1'b1;
                        ctl.wr_addr = ptr_reg[ADDR_W-1:0];
                    end
                    cnt_next = cnt_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    res_next.ok = 1'b1;
                    if (cmd_reg == CMD_QUERY)
                    begin
                        res_next.start_slot   = start_reg;
                        res_next.block_length = cnt_reg;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (out_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Registered read: address the slot the pointer moves to.
        ctl.rd_addr = ptr_next[ADDR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_length_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_length_reg <= used_length_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        run_reg   <= run_next;
        cnt_reg   <= cnt_next;
        size_reg  <= size_next;
        start_reg <= start_next;
        cmd_reg   <= cmd_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The used-length mark never moves down and never passes capacity.
    a_used_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> used_length_reg >= $past(used_length_reg))
        else $error("used length decreased");

    a_used_cap: assert property (@(posedge clk) disable iff (!rst_n)
        used_length_reg <= LEN_W'(SLOTS))
        else $error("used length beyond capacity");

    // Fill writes land below the used-length mark.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> ptr_reg < used_length_reg)
        else $error("fill outside used range");

    // A failure carries no start or length.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.start_slot == '0 && rsp.block_length == '0)
        else $error("failed response with nonzero fields");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for first_fit_block_allocator (allocate, free and query of slot blocks).
// Depends on ffba_pkg and the RTL. A model of the label table and used-length mark predicts each
// response; a clocked driver and monitor handle both valid/stall channels.
`timescale 1ns / 100ps

module tb
    import ffba_pkg::*;
();

    localparam int               IDLE_PCT     = 23;
    localparam int               RANDOM_ITEMS = 1930;
    // Longest allocate walks the whole table twice; leave margin for the drain.
    localparam int               DRAIN_CYCLES = 600;
    // Worst item: a full table search and fill, plus stalls; take that several times over.
    localparam int               LIMIT_CYCLES = 5000000;
    localparam int               SHOW_MAX     = 10;
    localparam int               REQ_W        = $bits(req_t);
    localparam logic [8:0]       EMPTY_LABEL  = 9'(SLOTS);

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Model of the allocator: one label per slot (EMPTY_LABEL when free) and the used mark.
    logic [8:0]  slot_label [SLOTS];
    int unsigned high_mark;

    req_t requests_todo [$];
    rsp_t answers_due [$];

    bit  req_taken;
    bit  quiet;
    int  cycles;
    int  errors;
    int  results_seen;
    int  results_ok;

    first_fit_block_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Label a run of slots as owned by the block that starts at its first slot.
    function automatic void claim_run(int unsigned first, int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++)
            slot_label[first + k] = first[8:0];
    endfunction

    // Apply one command to the model and return the response it must produce.
    function automatic rsp_t compute_answer(req_t r);
        rsp_t        a;
        int unsigned i, run, first, len, size, hint, slot;
        a    = '0;
        size = 32'(r.block_size);
        hint = 32'(r.search_start);
        slot = 32'(r.slot_index);
        case (cmd_t'(r.command))
            CMD_ALLOC:
            begin
                if (size == 0)
                    return a;
                // First fit from the hint, only below the used mark; a run that
                // reaches the mark is never stretched past it.
                run = 0;
                for (i = hint; i < high_mark; i++)
                begin
                    if (slot_label[i] == EMPTY_LABEL)
                    begin
                        run++;
                        if (run == size)
                        begin
                            first = i + 1 - size;
                            claim_run(first, size);
                            a.ok           = 1'b1;
                            a.start_slot   = first[7:0];
                            a.block_length = size[8:0];
                            return a;
                        end
                    end
                    else
                        run = 0;
                end
                // Append at the mark, or fail with no change when it would overflow.
                if (size > SLOTS - high_mark)
                    return a;
                first = high_mark;
                claim_run(first, size);
                high_mark += size;
                a.ok           = 1'b1;
                a.start_slot   = first[7:0];
                a.block_length = size[8:0];
            end
            CMD_FREE, CMD_QUERY:
            begin
                if (slot >= high_mark)
                    return a;
                first = 32'(slot_label[slot]);
                if (first == EMPTY_LABEL || first >= high_mark)
                    return a;
                // Walk from the block start while the label still matches.
                len = 0;
                for (i = first; i < high_mark && 32'(slot_label[i]) == first; i++)
                begin
                    if (r.command == CMD_FREE)
                        slot_label[i] = EMPTY_LABEL;
                    len++;
                end
                a.ok = 1'b1;
                if (r.command == CMD_QUERY)
                begin
                    a.start_slot   = first[7:0];
                    a.block_length = len[8:0];
                end
            end
            default:
                ;
        endcase
        return a;
    endfunction

    function automatic req_t make_req(cmd_t c, int size, int hint, int slot);
        req_t r;
        r.command      = c;
        r.block_size   = size[8:0];
        r.search_start = hint[8:0];
        r.slot_index   = slot[7:0];
        return r;
    endfunction

    // Append one item to the pending request queue.
    function automatic void plan_req(req_t r);
        requests_todo.insert(requests_todo.size(), r);
    endfunction

    // Driver: change inputs on the falling edge. Hold a stalled item; advance
    // to the next queued item only after the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (requests_todo.size() != 0
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    req_valid <= 1'b1;
                    req       <= requests_todo.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                    req       <= REQ_W'($urandom);
                end
            end
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Monitor: sample both handshakes on the rising edge. Predict on request
    // acceptance, check each response against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = req_valid && !req_stall;
            if (req_taken)
                answers_due.insert(answers_due.size(), compute_answer(req));
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (answers_due.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("unexpected response: ok=%0d start=%0d len=%0d",
                                 rsp.ok, rsp.start_slot, rsp.block_length);
                end
                else
                begin
                    rsp_t want;
                    want = answers_due.pop_front();
                    if (want.ok)
                        results_ok++;
                    if (rsp.ok !== want.ok || rsp.start_slot !== want.start_slot
                        || rsp.block_length !== want.block_length)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                            $display({"mismatch %0d at cycle %0d: ",
                                      "expected ok=%0d start=%0d len=%0d, ",
                                      "got ok=%0d start=%0d len=%0d"},
                                     errors, cycles, want.ok, want.start_slot,
                                     want.block_length, rsp.ok, rsp.start_slot,
                                     rsp.block_length);
                    end
                end
            end
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycles, answers_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int          n, pick, kind, tries;
        int unsigned s;
        req_t        r;

        for (n = 0; n < SLOTS; n++)
            slot_label[n] = EMPTY_LABEL;
        high_mark = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table failures, size extremes, append versus search,
        // hint past the mark, a free run touching the mark, frees and queries.
        plan_req(make_req(CMD_ALLOC, 0, 0, 0));
        plan_req(make_req(CMD_QUERY, 0, 0, 0));
        plan_req(make_req(CMD_FREE, 0, 0, 255));
        plan_req(make_req(CMD_NONE, 511, 511, 255));
        plan_req(make_req(CMD_ALLOC, 257, 0, 0));
        plan_req(make_req(CMD_ALLOC, 511, 511, 255));
        plan_req(make_req(CMD_ALLOC, 4, 0, 0));
        plan_req(make_req(CMD_ALLOC, 6, 300, 0));
        plan_req(make_req(CMD_ALLOC, 3, 0, 0));
        plan_req(make_req(CMD_QUERY, 0, 0, 5));
        plan_req(make_req(CMD_FREE, 0, 0, 2));
        plan_req(make_req(CMD_QUERY, 0, 0, 0));
        plan_req(make_req(CMD_ALLOC, 2, 0, 0));
        plan_req(make_req(CMD_ALLOC, 3, 0, 0));
        plan_req(make_req(CMD_FREE, 0, 0, 14));
        plan_req(make_req(CMD_FREE, 0, 0, 11));
        plan_req(make_req(CMD_ALLOC, 8, 0, 0));
        plan_req(make_req(CMD_ALLOC, 5, 3, 0));
        plan_req(make_req(CMD_QUERY, 0, 0, 255));
        plan_req(make_req(CMD_QUERY, 0, 0, 23));
        plan_req(make_req(CMD_ALLOC, 256, 0, 0));
        plan_req(make_req(CMD_FREE, 0, 0, 16));
        plan_req(make_req(CMD_QUERY, 0, 0, 16));

        // Random: mostly sensible commands aimed at live blocks and holes,
        // some noise. Generate lazily so the mix follows the table's state.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 400 == 0)
                while (requests_todo.size() != 0 || req_valid || answers_due.size() != 0)
                    @(posedge clk);
            quiet = (n >= 600 && n < 900);
            while (requests_todo.size() >= 2)
                @(posedge clk);

            r    = REQ_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 42)
            begin
                r.command = CMD_ALLOC;
                kind      = $urandom_range(0, 99);
                if (kind < 65)
                    r.block_size = 9'($urandom_range(1, 8));
                else if (kind < 82)
                    r.block_size = 9'($urandom_range(9, 48));
                else if (kind < 88)
                    r.block_size = 9'((high_mark < SLOTS) ? SLOTS - high_mark : 1);
                else if (kind < 94)
                    r.block_size = 9'($urandom_range(0, 511));
                else
                    r.block_size = 9'($urandom_range(256, 511));
                kind = $urandom_range(0, 99);
                if (kind < 60)
                    r.search_start = '0;
                else if (kind < 80)
                    r.search_start = 9'($urandom_range(0, high_mark));
                else if (kind < 92)
                    r.search_start = 9'($urandom_range(0, 511));
                else
                    r.search_start = 9'(high_mark);
            end
            else if (pick < 95)
            begin
                r.command = (pick < 70) ? CMD_FREE : CMD_QUERY;
                s         = $urandom_range(0, 255);
                if (high_mark > 0 && $urandom_range(0, 99) < 85)
                begin
                    for (tries = 0; tries < 8; tries++)
                    begin
                        s = $urandom_range(0, high_mark - 1);
                        if (slot_label[s] != EMPTY_LABEL)
                            break;
                    end
                end
                r.slot_index = s[7:0];
            end
            else
                r.command = CMD_NONE;
            plan_req(r);
        end

        // Let every item go in, every response come back, then drain.
        while (requests_todo.size() != 0 || req_valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d responses (%0d successful), used mark reached %0d of %0d slots",
                 results_seen, results_ok, high_mark, SLOTS);
        $display("mismatches: %0d, cycles: %0d", errors, cycles);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
